// ----- rtl/ris_pkg.sv -----
// Shared widths and register index codes for the ring and island distance block.
package ris_pkg;

	// Coordinate, radius and result widths.
	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int OUT_W   = 27;

	// Internal widths: exact difference, its magnitude, the sum of squares and the root.
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = DIFF_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int DIST_W  = ROOT_W + 1;

	// One root bit is settled in each square root stage.
	localparam int SQRT_STEPS = ROOT_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_OUTER_CX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_CY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RAD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ISLAND_CX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ISLAND_CY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ISLAND_RAD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIGN_FLIP = 3'd6;

endpackage

// ----- rtl/ris_sqrt.sv -----
// Pipelined floor square root, one root bit per stage.
module ris_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ris_pkg::SQ_W-1:0]    radicand,
	output logic                        out_valid,
	output logic [ris_pkg::ROOT_W-1:0]  root
);
	import ris_pkg::*;

	logic [SQ_W-1:0] rem_s  [SQRT_STEPS];
	logic [SQ_W:0]   root_s [SQRT_STEPS];
	logic            vld_s  [SQRT_STEPS];

	genvar g;
	generate
		for (g = 0; g < SQRT_STEPS; g++) begin : g_step
			localparam int K = SQRT_STEPS - 1 - g;
			localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (2 * K);

			logic [SQ_W-1:0] rem_in;
			logic [SQ_W:0]   root_in;
			logic            vld_in;
			logic [SQ_W:0]   trial;
			logic [SQ_W:0]   diff;
			logic            fits;

			// The first stage takes the radicand; later ones take the stage before.
			if (g == 0) begin : g_first
				assign rem_in  = radicand;
				assign root_in = '0;
				assign vld_in  = in_valid;
			end else begin : g_next
				assign rem_in  = rem_s[g-1];
				assign root_in = root_s[g-1];
				assign vld_in  = vld_s[g-1];
			end

			// Trial subtraction of the current root candidate.
			always_comb begin
				trial = root_in + BIT;
				diff  = {1'b0, rem_in} - trial;
				fits  = ({1'b0, rem_in} >= trial);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en) begin
					vld_s[g] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g]  <= fits ? diff[SQ_W-1:0] : rem_in;
					root_s[g] <= fits ? ((root_in >> 1) + BIT) : (root_in >> 1);
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign root      = root_s[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ----- rtl/ris_dist.sv -----
// Pipelined Euclidean distance from a centre to the query point.
module ris_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [ris_pkg::COORD_W-1:0] center_x,
	input  logic signed [ris_pkg::COORD_W-1:0] center_y,
	input  logic signed [ris_pkg::COORD_W-1:0] point_x,
	input  logic signed [ris_pkg::COORD_W-1:0] point_y,
	output logic                               out_valid,
	output logic [ris_pkg::ROOT_W-1:0]         distance
);
	import ris_pkg::*;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [MAG_W-1:0]         ax_s2, ay_s2;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3;
	logic [SQ_W-1:0]          sum_s4;
	logic                     v_s1, v_s2, v_s3, v_s4;

	// Valid bits follow the data through the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Exact differences, magnitudes, squares and their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DIFF_W'(center_x) - DIFF_W'(point_x);
			dy_s1  <= DIFF_W'(center_y) - DIFF_W'(point_y);
			ax_s2  <= dx_s1[DIFF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
			ay_s2  <= dy_s1[DIFF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
			sqx_s3 <= ax_s2 * ax_s2;
			sqy_s3 <= ay_s2 * ay_s2;
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	ris_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.radicand  (sum_s4),
		.out_valid (out_valid),
		.root      (distance)
	);

endmodule

// ----- rtl/ris_skid.sv -----
// Output register with a skid entry, so that the pipeline is parted from the consumer.
module ris_skid (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic signed [ris_pkg::OUT_W-1:0]   push_data,
	output logic                               space,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ris_pkg::OUT_W-1:0]   out_data
);
	import ris_pkg::*;

	logic                    out_vld_q;
	logic                    skid_vld_q;
	logic signed [OUT_W-1:0] out_data_q;
	logic signed [OUT_W-1:0] skid_data_q;

	// The output takes the skid entry first; a beat that cannot leave parks in the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_data_q <= skid_vld_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign space     = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

// ----- rtl/ring_island_signed_distance.sv -----
// Top level of the ring and island signed distance pipeline.
// One point enters in every cycle unless the pipeline holds, and one signed distance leaves
// for each, in order. A beat passes 33 registers: four of difference, magnitude, square and
// sum, 25 of the square root pipeline (one root bit a stage, both circles side by side),
// three of subtract, select and sign, and the output register. The first of them is loaded
// at the edge that takes the point. The whole pipeline holds while the skid entry in front
// of the output is full, so in_ready comes straight from a register. Configuration writes
// are taken at once and must only be made while no point is in flight.
module ring_island_signed_distance (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ris_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ris_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ris_pkg::COORD_W-1:0]    point_x,
	input  logic signed [ris_pkg::COORD_W-1:0]    point_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ris_pkg::OUT_W-1:0]      signed_distance
);
	import ris_pkg::*;

	logic signed [COORD_W-1:0] outer_cx_q, outer_cy_q, island_cx_q, island_cy_q;
	logic [RAD_W-1:0]          outer_rad_q, island_rad_q;
	logic                      sign_flip_q;

	logic                      en;
	logic                      accept;
	logic                      outer_vld, island_vld;
	logic [ROOT_W-1:0]         outer_dist, island_dist;

	logic signed [DIST_W-1:0]  d1_s1, alt_s1, res_s2;
	logic signed [OUT_W-1:0]   res_ext;
	logic signed [OUT_W-1:0]   out_s3;
	logic                      v_s1, v_s2, v_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_cx_q   <= '0;
			outer_cy_q   <= '0;
			outer_rad_q  <= '0;
			island_cx_q  <= '0;
			island_cy_q  <= '0;
			island_rad_q <= '0;
			sign_flip_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUTER_CX:   outer_cx_q   <= cfg_data;
				REG_OUTER_CY:   outer_cy_q   <= cfg_data;
				REG_OUTER_RAD:  outer_rad_q  <= cfg_data[RAD_W-1:0];
				REG_ISLAND_CX:  island_cx_q  <= cfg_data;
				REG_ISLAND_CY:  island_cy_q  <= cfg_data;
				REG_ISLAND_RAD: island_rad_q <= cfg_data[RAD_W-1:0];
				REG_SIGN_FLIP:  sign_flip_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline advances whenever the skid entry is free.
	assign in_ready = en;
	assign accept   = in_valid && en;

	ris_dist u_outer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (accept),
		.center_x  (outer_cx_q),
		.center_y  (outer_cy_q),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (outer_vld),
		.distance  (outer_dist)
	);

	ris_dist u_island (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (accept),
		.center_x  (island_cx_q),
		.center_y  (island_cy_q),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (island_vld),
		.distance  (island_dist)
	);

	// Valid bits of the tail stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= outer_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Distance to the ring, the island term, the larger of the two inside the ring, the sign.
	assign res_ext = OUT_W'(res_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1  <= $signed({1'b0, outer_dist}) - $signed({3'b000, outer_rad_q});
			alt_s1 <= $signed({3'b000, island_rad_q}) - $signed({1'b0, island_dist});
			res_s2 <= (d1_s1[DIST_W-1] && (alt_s1 > d1_s1)) ? alt_s1 : d1_s1;
			out_s3 <= sign_flip_q ? -res_ext : res_ext;
		end
	end

	ris_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3 && en),
		.push_data (out_s3),
		.space     (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (signed_distance)
	);

	// Both distance pipelines carry the same beats.
	assert property (@(posedge clk) disable iff (!arst_n) outer_vld == island_vld)
		else $error("outer and island distance pipelines out of step");

	// A full skid entry always sits behind a waiting output.
	assert property (@(posedge clk) disable iff (!arst_n) !in_ready |-> out_valid)
		else $error("pipeline stalled with no result on the output");

	// The skid entry stays full until the consumer takes the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && !out_ready) |=> !in_ready)
		else $error("skid entry lost while the output was stalled");

	// A stalled pipeline holds its last stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(out_s3) && $stable(v_s3)))
		else $error("tail stage changed during a stall");

endmodule

// ----- tb/tb_ring_island_signed_distance.sv -----
// Self-checking testbench for the ring and island signed distance pipeline.
`timescale 1ns / 100ps

module tb_ring_island_signed_distance;
	import ris_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int PHASE_POINTS = 210;

	// Index with no register behind it: writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Predicts the distance for each accepted point and checks the results in order.
	class distance_scoreboard;
		logic signed [COORD_W-1:0] ocx = '0, ocy = '0, icx = '0, icy = '0;
		logic [RAD_W-1:0] orad = '0, irad = '0;
		bit flip = 1'b0;
		logic signed [OUT_W-1:0] expected_distance[$];
		int errors = 0;

		function void take_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_OUTER_CX:   ocx = data;
				REG_OUTER_CY:   ocy = data;
				REG_OUTER_RAD:  orad = data[RAD_W-1:0];
				REG_ISLAND_CX:  icx = data;
				REG_ISLAND_CY:  icy = data;
				REG_ISLAND_RAD: irad = data[RAD_W-1:0];
				REG_SIGN_FLIP:  flip = data[0];
				default: ;
			endcase
		endfunction

		// Floor square root, settled one bit at a time from the top.
		function longint unsigned floor_root(longint unsigned n);
			longint unsigned root, trial;
			root = 0;
			for (int b = 25; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= n)
					root = trial;
			end
			return root;
		endfunction

		function longint separation(longint ax, longint ay, longint bx, longint by);
			longint dx, dy;
			dx = ax - bx;
			dy = ay - by;
			return longint'(floor_root(longint'(dx * dx + dy * dy)));
		endfunction

		function logic signed [OUT_W-1:0] predict_distance(logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y);
			longint d, alt;
			d = separation(ocx, ocy, x, y) - longint'(orad);
			// Inside the outer circle the island may be the nearer part of the front.
			if (d < 0) begin
				alt = longint'(irad) - separation(icx, icy, x, y);
				if (alt > d)
					d = alt;
			end
			if (flip)
				d = -d;
			return d[OUT_W-1:0];
		endfunction

		function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
			expected_distance.push_back(predict_distance(x, y));
		endfunction

		function void check_distance(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (expected_distance.size() == 0) begin
				$error("signed_distance: unexpected beat, actual %0d", got);
				errors++;
			end else begin
				want = expected_distance.pop_front();
				if (got !== want) begin
					$error("signed_distance mismatch: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [COORD_W-1:0] point_x, point_y;
	logic out_valid, out_ready;
	logic signed [OUT_W-1:0] signed_distance;

	distance_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_request = 1'b0;

	ring_island_signed_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.signed_distance(signed_distance)
	);

	always #5 clk = ~clk;

	// Monitors: register writes, accepted points and accepted results at the rising edge.
	always @(posedge clk) begin
		if (arst_n && cfg_we)
			sb.take_write(cfg_index, cfg_data);
		if (arst_n && in_valid && in_ready)
			sb.note_point(point_x, point_y);
		if (arst_n && out_valid && out_ready)
			sb.check_distance(signed_distance);
	end

	// Result side: random back-pressure, a calm stretch, and one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 25);
			end
		end
	end

	// Drives one register write; the caller lowers the write enable afterwards.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic write_setting(input logic [CFG_DATA_W-1:0] ocx, ocy, orad, icx, icy, irad,
			flip);
		put_reg(REG_OUTER_CX, ocx);
		put_reg(REG_OUTER_CY, ocy);
		put_reg(REG_OUTER_RAD, orad);
		put_reg(REG_ISLAND_CX, icx);
		put_reg(REG_ISLAND_CY, icy);
		put_reg(REG_ISLAND_RAD, irad);
		put_reg(REG_SIGN_FLIP, flip);
		put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_coord();
		if ($urandom_range(1))
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'($urandom_range(0, 1 << 21)) - CFG_DATA_W'(1 << 20);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_radius();
		if ($urandom_range(4) == 0)
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'($urandom_range(0, 1 << 20));
	endfunction

	// Island placed near the outer centre most of the time, so that it sits inside the ring.
	task automatic random_setting();
		logic [CFG_DATA_W-1:0] ocx, ocy, icx, icy;
		ocx = random_coord();
		ocy = random_coord();
		icx = ocx + CFG_DATA_W'($urandom_range(0, 1 << 19)) - CFG_DATA_W'(1 << 18);
		icy = ocy + CFG_DATA_W'($urandom_range(0, 1 << 19)) - CFG_DATA_W'(1 << 18);
		if ($urandom_range(3) == 0)
			icx = random_coord();
		write_setting(ocx, ocy, random_radius(), icx, icy, random_radius(),
			CFG_DATA_W'($urandom));
	endtask

	// Points mostly scattered around one of the two circles, the rest anywhere.
	task automatic random_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
		int sel;
		longint span, bx, by;
		sel = $urandom_range(99);
		if (sel < 45) begin
			bx = sb.ocx;
			by = sb.ocy;
			span = longint'(sb.orad) + 'h8000;
		end else begin
			bx = sb.icx;
			by = sb.icy;
			span = longint'(sb.irad) + 'h8000;
		end
		if (span > (1 << 22))
			span = 1 << 22;
		x = COORD_W'(bx + longint'($urandom_range(0, 32'(2 * span))) - span);
		y = COORD_W'(by + longint'($urandom_range(0, 32'(2 * span))) - span);
		if (sel >= 75) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
	endtask

	// Offers one point, with random idle cycles in front outside a calm stretch, and returns after its beat.
	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		if (!calm) begin
			while ($urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Closes a burst and waits for every predicted distance to come back.
	task automatic finish_burst();
		in_valid <= 1'b0;
		while (sb.expected_distance.size() != 0)
			@(negedge clk);
	endtask

	// Run watchdog.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAIL ring_island_signed_distance");
		$finish;
	end

	initial begin
		logic [COORD_W-1:0] x, y;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting: everything at zero, points at the origin and the corners of the range.
		send_point(24'h000000, 24'h000000);
		send_point(24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'h800000);
		send_point(24'h800000, 24'h7FFFFF);
		send_point(24'h7FFFFF, 24'h800000);
		finish_burst();

		// Ring of radius 16 with an island of radius 4 inside it.
		write_setting(24'h001000, 24'hFFE000, 24'h010000, 24'h003000, 24'hFFF000, 24'h004000,
			24'h000000);
		send_point(24'h001000, 24'hFFE000);
		send_point(24'h011000, 24'hFFE000);
		send_point(24'h003000, 24'hFFF000);
		send_point(24'h007000, 24'hFFF000);
		send_point(24'h001000, 24'h00C000);
		send_point(24'h001000, 24'h00E000);
		send_point(24'h001000, 24'h012000);
		send_point(24'h7FFFFF, 24'h800000);
		send_point(24'h800000, 24'h7FFFFF);
		finish_burst();

		// Same ring with the sign flipped; spare high bits in the radius and flag words.
		write_setting(24'h001000, 24'hFFE000, 24'h810000, 24'h003000, 24'hFFF000, 24'h804000,
			24'hABCDEF);
		send_point(24'h011000, 24'hFFE000);
		send_point(24'h001000, 24'hFFE000);
		send_point(24'h003000, 24'hFFF000);
		send_point(24'h000000, 24'h000000);
		send_point(24'h7FFFFF, 24'h7FFFFF);
		finish_burst();

		// Random phases: two at the extremes of the registers, the rest random.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_setting(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
					24'h7FFFFF, 24'h000000);
				1: write_setting(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF,
					24'h7FFFFF, 24'h000001);
				default: random_setting();
			endcase
			calm = (phase == 3);
			if (phase == 2)
				hold_request = 1'b1;
			repeat (PHASE_POINTS) begin
				random_point(x, y);
				send_point(x, y);
			end
			finish_burst();
			calm = 1'b0;
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("PASS ring_island_signed_distance");
		else
			$display("FAIL ring_island_signed_distance");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ris_pkg.sv
rtl/ris_sqrt.sv
rtl/ris_dist.sv
rtl/ris_skid.sv
rtl/ring_island_signed_distance.sv
tb/tb_ring_island_signed_distance.sv
